/* rtl/core/tkds_pkg.sv */
`default_nettype none

package tkds_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PRI_W    = 10;
    localparam int SEC_W    = 8;
    localparam int IDX_W    = 6;
    localparam int KEY_W    = PRI_W + SEC_W;

    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [PRI_W-1:0] pri;
        logic [IDX_W-1:0] idx;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    function automatic logic [KEY_W-1:0] rec_key(rec_t r);
        return {r.pri, r.sec};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tkds_cell.sv */
`default_nettype none

module tkds_cell
    import tkds_pkg::*;
(
    input  wire             aclk,
    input  wire cell_ctl_t  ctl,
    input  wire rec_t       new_rec,
    input  wire rec_t       prev_rec,
    input  wire rec_t       next_rec,
    input  wire             prev_keep,
    input  wire             occupied,
    output rec_t            rec_q,
    output logic            keep
);

    rec_t rec_reg;
    rec_t rec_next;

    // stored record stays put when it sorts ahead of or ties with the new one
    assign keep = occupied && (rec_key(rec_reg) >= rec_key(new_rec));

    always_comb begin
        rec_next = rec_reg;
        if (ctl.insert) begin
            if (keep) begin
                rec_next = rec_reg;
            end else if (prev_keep) begin
                rec_next = new_rec;
            end else begin
                rec_next = prev_rec;
            end
        end else if (ctl.shift) begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec_q = rec_reg;

endmodule

`default_nettype wire

/* rtl/core/tkds_ctrl.sv */
`default_nettype none

module tkds_ctrl
    import tkds_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    input  wire               s_tlast,
    input  wire               m_tready,
    output logic              s_tready,
    output logic              m_tvalid,
    output logic              m_tlast,
    output logic              overflow,
    output logic [CNT_W-1:0]  count,
    output cell_ctl_t         ctl
);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              s_acc;
    logic              m_acc;
    logic              full;
    logic              last_one;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign last_one = (count_reg == CNT_W'(1));
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_acc && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (m_acc && last_one) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_LOAD:  s_tready = 1'b1;
            ST_DRAIN: m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign ctl.insert = s_acc && !full;
    assign ctl.shift  = m_acc;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (ctl.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.shift) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (s_acc && full) begin
            ovf_next = 1'b1;
        end else if (m_acc && last_one) begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_tlast  = last_one;
    assign overflow = ovf_reg;
    assign count    = count_reg;

endmodule

`default_nettype wire

/* rtl/core/two_key_descending_stable_sort.sv */
`default_nettype none

// two-key descending stable sorter. records stream in on the s_ side, one
// word per cycle, and drop straight into place in a row of compare-and-shift
// cells: each cell compares its record with the incoming one in parallel and
// either holds, takes the new record, or takes its left neighbor's record.
// order is descending primary key, then descending secondary key; records
// that tie on both keys keep their arrival order. each record is tagged with
// its arrival position in the set, from 0. while loading, one word is
// accepted every cycle. the word with tlast closes the set: it is stored
// (if there is room) and s_tready drops while the cells shift the sorted set
// out of cell 0, one record per cycle on the m_ side while m_tready is high,
// m_tlast on the final one. words beyond 64 records are dropped and m_tuser
// is high on every output word of that set. after the final output word the
// block is empty and takes the next set at once.

module two_key_descending_stable_sort
    import tkds_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [23:0]  s_tdata,   // primary_key[9:0], secondary_key[17:10], zero fill
    input  wire         s_tlast,   // last_item
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // record_index[5:0], primary_out[15:6], secondary_out[23:16]
    output logic        m_tuser,   // overflowed
    output logic        m_tlast    // last_result
);

    logic [CNT_W-1:0]     count;
    logic                 overflow;
    cell_ctl_t            ctl;
    rec_t                 new_rec;
    rec_t                 cell_rec [CAPACITY];
    logic [CAPACITY-1:0]  cell_keep;

    // control: load/drain sequencing, fill count and overflow flag
    tkds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .overflow (overflow),
        .count    (count),
        .ctl      (ctl)
    );

    // incoming record, tagged with its arrival position
    assign new_rec.pri = s_tdata[PRI_W-1:0];
    assign new_rec.sec = s_tdata[KEY_W-1:PRI_W];
    assign new_rec.idx = IDX_W'(count);

    // cell row: cell 0 holds the record that goes out first
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        rec_t prev_rec;
        rec_t next_rec;
        logic prev_keep;
        logic occupied;

        // cells below the fill count hold live records
        assign occupied = (count > CNT_W'(i));

        if (i == 0) begin : g_head
            // left edge acts as a record that always sorts ahead
            assign prev_rec  = new_rec;
            assign prev_keep = 1'b1;
        end else begin : g_body
            assign prev_rec  = cell_rec[i-1];
            assign prev_keep = cell_keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            // nothing shifts in past the end; count marks it empty
            assign next_rec = cell_rec[i];
        end else begin : g_mid
            assign next_rec = cell_rec[i+1];
        end

        tkds_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_rec   (new_rec),
            .prev_rec  (prev_rec),
            .next_rec  (next_rec),
            .prev_keep (prev_keep),
            .occupied  (occupied),
            .rec_q     (cell_rec[i]),
            .keep      (cell_keep[i])
        );
    end

    // output word straight from cell 0
    assign m_tdata = {cell_rec[0].sec, cell_rec[0].pri, cell_rec[0].idx};
    assign m_tuser = overflow;

    // fill count never passes the cell row
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // a result is only offered while records remain in the row
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count != '0))
        else $error("output valid with empty cell row");

    // final output word empties the row and reopens the input
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count == '0 && !m_tuser))
        else $error("row not cleared after final output word");

    // loading and draining never overlap
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

endmodule

`default_nettype wire
